[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RPN evaluator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk, masked while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion clocked on clk, also checked across reset release.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared widths, token and status codes, and the ALU request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_FINISH = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_EMPTY = 2'd1,
    STATUS_INVALID   = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  typedef logic signed [DATA_W-1:0] q16_t;

  // Operands for one binary operator token
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    q16_t              older;
    q16_t              newer;
  } alu_req_t;

endpackage

[sv/rpn_alu.sv]
// ----------------------------------------------------------------------------
// RPN ALU
// Saturating Q16.16 add, subtract and multiply on the top two stack entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_alu (
  input  rpn_pkg::alu_req_t req_i,
  output rpn_pkg::q16_t     res_o
);
  import rpn_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;

  logic signed [DATA_W:0]   sum;
  logic signed [PROD_W-1:0] prod;
  q16_t                     sum_sat;
  q16_t                     mul_sat;
  logic                     mul_fits;

  localparam q16_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q16_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  always_comb begin
    if (req_i.kind == KIND_SUB) begin
      sum = {req_i.older[DATA_W-1], req_i.older} - {req_i.newer[DATA_W-1], req_i.newer};
    end else begin
      sum = {req_i.older[DATA_W-1], req_i.older} + {req_i.newer[DATA_W-1], req_i.newer};
    end
  end

  assign sum_sat = (sum[DATA_W] != sum[DATA_W-1]) ? (sum[DATA_W] ? Q_MIN : Q_MAX)
                                                  : sum[DATA_W-1:0];

  // Full product, then floor shift by FRAC_W (arithmetic shift = round to -inf)
  assign prod     = PROD_W'(req_i.older) * PROD_W'(req_i.newer);
  assign mul_fits = (prod[PROD_W-1:DATA_W+FRAC_W-1] == '0)
                 || (prod[PROD_W-1:DATA_W+FRAC_W-1] == '1);
  assign mul_sat  = mul_fits ? prod[DATA_W+FRAC_W-1:FRAC_W]
                             : (prod[PROD_W-1] ? Q_MIN : Q_MAX);

  always_comb begin
    case (req_i.kind)
      KIND_MUL: res_o = mul_sat;
      default:  res_o = sum_sat;
    endcase
  end

endmodule

[sv/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Evaluates reverse Polish expressions of Q16.16 tokens on a bounded stack.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens arrive on the s_axis channel: tuser carries the token kind
//   (push, add, subtract, multiply, finish), tdata the Q16.16 number for a
//   push. Only a finish token produces a request on m_axis: tdata holds the
//   final value (zero unless status is ok) and tuser the status code.
//   Kinds 5 to 7 are consumed and ignored.
// Throughput:
//   One token per cycle unless a finish waits on a full output slot. A token
//   is registered on accept and executed from the input register on the top
//   two stack entries; a finish sets m_axis_tvalid from the output register.
// Stall:
//   While a result waits on m_axis, push and operator tokens keep flowing;
//   a further finish waits in the input register and backpressures s_axis.
// Reset:
//   Clears the fill level, the sticky overflow flag and both valid flags.
//   Stack entries hold no reset; entries above the fill level are never used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF  // 2 .. 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // token input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rpn_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] number
  input  logic [rpn_pkg::KIND_W-1:0]     s_axis_tuser,   // [2:0] kind
  // expression result
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rpn_pkg::DATA_W-1:0]     m_axis_tdata,   // [31:0] result
  output logic [rpn_pkg::STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);
  import rpn_pkg::*;

  localparam int unsigned FILL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STACK_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

  // Input register
  logic              in_valid_q;
  logic [KIND_W-1:0] in_kind_q;
  q16_t              in_num_q;

  // Stack: entry 0 is the top; entries shift on push and pop
  q16_t              ent_val_q [STACK_DEPTH];
  logic              ent_inv_q [STACK_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;

  // Output register
  logic              out_valid_q;
  q16_t              out_result_q;
  status_e           out_status_q;

  logic     out_free, advance;
  logic     do_push, do_bin, do_fin;
  logic     has1, has2, full;
  logic     newer_inv, older_inv, bin_inv;
  q16_t     alu_res, bin_val;
  alu_req_t alu_req;
  status_e  fin_status;

  assign out_free      = !out_valid_q || m_axis_tready;
  // a finish can only leave the input register when the output slot frees
  assign advance       = in_valid_q && ((in_kind_q != KIND_FINISH) || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  assign has1 = (fill_q != '0);
  assign has2 = (fill_q > FILL_ONE);
  assign full = (fill_q == FILL_FULL);

  // popping an empty stack yields an invalid operand
  assign newer_inv = !has1 || ent_inv_q[0];
  assign older_inv = !has2 || ent_inv_q[1];
  assign bin_inv   = newer_inv || older_inv;

  assign alu_req.kind  = in_kind_q;
  assign alu_req.older = ent_val_q[1];
  assign alu_req.newer = ent_val_q[0];

  rpn_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign bin_val = bin_inv ? '0 : alu_res;

  always_comb begin
    do_push = 1'b0;
    do_bin  = 1'b0;
    do_fin  = 1'b0;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    if (advance) begin
      case (in_kind_q)
        KIND_PUSH: begin
          if (full) begin
            ovf_d = 1'b1;  // dropped push, sticky until next finish
          end else begin
            do_push = 1'b1;
            fill_d  = fill_q + FILL_ONE;
          end
        end
        KIND_ADD, KIND_SUB, KIND_MUL: begin
          do_bin = 1'b1;
          // two pops then one push; short stack ends with one invalid entry
          fill_d = has2 ? (fill_q - FILL_ONE) : FILL_ONE;
        end
        KIND_FINISH: begin
          do_fin = 1'b1;
          fill_d = '0;
          ovf_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // priority: overflow, leftover entries, invalid value, ok
  always_comb begin
    if (ovf_q) begin
      fin_status = STATUS_OVERFLOW;
    end else if (has2) begin
      fin_status = STATUS_NOT_EMPTY;
    end else if (newer_inv) begin
      fin_status = STATUS_INVALID;
    end else begin
      fin_status = STATUS_OK;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      if (do_fin) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser;
      in_num_q  <= s_axis_tdata;
    end
    if (do_fin) begin
      out_status_q <= fin_status;
      out_result_q <= (fin_status == STATUS_OK) ? ent_val_q[0] : '0;
    end
    if (do_push) begin
      ent_val_q[0] <= in_num_q;
      ent_inv_q[0] <= 1'b0;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        ent_val_q[i] <= ent_val_q[i-1];
        ent_inv_q[i] <= ent_inv_q[i-1];
      end
    end else if (do_bin) begin
      ent_val_q[0] <= bin_val;
      ent_inv_q[0] <= bin_inv;
      for (int i = 1; i < STACK_DEPTH - 1; i++) begin
        ent_val_q[i] <= ent_val_q[i+1];
        ent_inv_q[i] <= ent_inv_q[i+1];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_result_q;
  assign m_axis_tuser  = out_status_q;

endmodule

[sv/rpn_checker.sv]
// ----------------------------------------------------------------------------
// RPN evaluator checker
// Port-level assertions for the RPN stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rpn_pkg::KIND_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rpn_pkg::DATA_W-1:0]     m_axis_tdata,
  input logic [rpn_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import rpn_pkg::*;

  // stalled result request holds its payload
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
                && $stable(m_axis_tdata) && $stable(m_axis_tuser),
              "result changed while stalled")

  // only an ok status carries a value
  `ASSERT_CLK(a_err_zero, clk_i, rst_ni,
              m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tdata == '0,
              "nonzero value with error status")

  // a fresh result follows an accepted finish token through the input and output registers
  `ASSERT_CLK(a_out_cause, clk_i, rst_ni,
              $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready
                && (s_axis_tuser == KIND_FINISH), 2),
              "result without finish token")

  // no result pending right after reset release
  `ASSERT_CLK_NORST(a_reset_idle, clk_i, $rose(rst_ni) |-> !m_axis_tvalid,
                    "result valid out of reset")

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// RPN stack evaluator testbench
// Streams random and directed token sequences into the evaluator, predicts
// each finish outcome with a local stack model, and compares every result
// request field by field, with random idle and stall cycles on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import rpn_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;

  typedef struct {
    logic [KIND_W-1:0] kind;
    q16_t              number;
  } token_t;

  typedef struct {
    q16_t    value;
    status_e status;
  } outcome_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata  = '0;  // [31:0] number
  logic [KIND_W-1:0]   s_axis_tuser  = '0;  // [2:0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;        // [31:0] result
  logic [STATUS_W-1:0] m_axis_tuser;        // [1:0] status

  rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // token stream still to be driven, and finish outcomes still to arrive
  token_t   token_q[$];
  outcome_t outcome_q[$];

  int unsigned tok_sent     = 0;
  int unsigned tok_accepted = 0;
  int unsigned res_taken    = 0;
  int unsigned res_seen     = 0;
  int unsigned live_tokens  = 0;
  int unsigned fail_count   = 0;

  int unsigned s_gap   = 0;
  int unsigned s_burst = 0;
  int unsigned m_wait  = 0;
  int unsigned m_burst = 0;

  // operand stack mirror
  q16_t        stk_val[DEPTH];
  bit          stk_bad[DEPTH];
  int unsigned stk_fill   = 0;
  bit          ovf_sticky = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic q16_t clamp_q16(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return q16_t'(v);
  endfunction

  function automatic void push_operand(q16_t v, bit bad);
    if (stk_fill >= DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      stk_val[stk_fill] = bad ? q16_t'(0) : v;
      stk_bad[stk_fill] = bad;
      stk_fill++;
    end
  endfunction

  // an empty stack hands out an invalid operand
  function automatic void pop_operand(output q16_t v, output bit bad);
    if (stk_fill == 0) begin
      v   = '0;
      bad = 1'b1;
    end else begin
      stk_fill--;
      v   = stk_val[stk_fill];
      bad = stk_bad[stk_fill];
    end
  endfunction

  function automatic void eval_token(logic [KIND_W-1:0] kind, q16_t number);
    q16_t     newer, older, res;
    bit       bad_n, bad_o;
    longint   prod;
    outcome_t o;
    res   = '0;
    bad_o = 1'b0;
    case (kind)
      KIND_PUSH: push_operand(number, 1'b0);
      KIND_ADD, KIND_SUB, KIND_MUL: begin
        pop_operand(newer, bad_n);
        pop_operand(older, bad_o);
        if (!(bad_n || bad_o)) begin
          if (kind == KIND_ADD) begin
            res = clamp_q16(longint'(older) + longint'(newer));
          end else if (kind == KIND_SUB) begin
            res = clamp_q16(longint'(older) - longint'(newer));
          end else begin
            // arithmetic shift floors, i.e. rounds toward minus infinity
            prod = longint'(older) * longint'(newer);
            res  = clamp_q16(prod >>> FRAC_W);
          end
        end
        push_operand(res, bad_n || bad_o);
      end
      KIND_FINISH: begin
        pop_operand(res, bad_n);
        o.value = '0;
        if (ovf_sticky) begin
          o.status = STATUS_OVERFLOW;
        end else if (stk_fill != 0) begin
          o.status = STATUS_NOT_EMPTY;
        end else if (bad_n) begin
          o.status = STATUS_INVALID;
        end else begin
          o.status = STATUS_OK;
          o.value  = res;
        end
        stk_fill   = 0;
        ovf_sticky = 1'b0;
        outcome_q.push_back(o);
      end
      default: ;  // kinds 5..7 are dropped
    endcase
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic q16_t rand_number();
    case ($urandom_range(0, 5))
      0: return q16_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '0;
          3:       return -1;
          default: return 32'sh0001_0000;
        endcase
      end
      2, 3: return q16_t'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      default: return q16_t'(int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_op();
    case ($urandom_range(0, 2))
      0:       return KIND_ADD;
      1:       return KIND_SUB;
      default: return KIND_MUL;
    endcase
  endfunction

  function automatic void add_token(logic [KIND_W-1:0] kind, q16_t number);
    token_t t;
    t.kind   = kind;
    t.number = number;
    token_q.push_back(t);
    if (kind <= KIND_FINISH) live_tokens++;
  endfunction

  // well-formed expression over n numbers, closed by a finish
  function automatic void emit_expression(int unsigned n);
    int unsigned pushed, held;
    pushed = 0;
    held   = 0;
    while (pushed < n || held > 1) begin
      if (held >= 2 && (pushed == n || $urandom_range(0, 2) == 0)) begin
        add_token(rand_op(), rand_number());
        held--;
      end else begin
        add_token(KIND_PUSH, rand_number());
        pushed++;
        held++;
      end
      if ($urandom_range(0, 49) == 0) begin
        add_token(KIND_W'($urandom_range(5, 7)), q16_t'($urandom));
      end
    end
    add_token(KIND_FINISH, rand_number());
  endfunction

  // per-request wait, with occasional stretches of back-to-back traffic
  function automatic int unsigned pick_wait(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------- clock / reset

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    token_t t;
    if (rst_ni) begin
      if (!s_axis_tvalid || tok_accepted == tok_sent) begin
        if (s_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          s_gap = s_gap - 1;
        end else if (token_q.size() != 0) begin
          t = token_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= t.kind;
          s_axis_tdata  <= t.number;
          tok_sent++;
          s_gap = pick_wait(s_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink: stall counts down only while a result is offered
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken != res_seen) begin
        res_seen = res_taken;
        m_wait   = pick_wait(m_burst);
      end
      if (m_wait != 0) begin
        m_axis_tready <= 1'b0;
        if (m_axis_tvalid) m_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tok_accepted++;
        eval_token(s_axis_tuser, q16_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        res_taken++;
        if (outcome_q.size() == 0) begin
          report_failure($sformatf("unexpected result value=%h status=%0d",
                                   m_axis_tdata, m_axis_tuser));
        end else begin
          o = outcome_q.pop_front();
          if (m_axis_tdata !== o.value || m_axis_tuser !== o.status) begin
            report_failure($sformatf("result mismatch: exp value=%h status=%0d, got value=%h status=%0d",
                                     o.value, o.status, m_axis_tdata, m_axis_tuser));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned shape;

    // finish on an empty stack: invalid
    add_token(KIND_FINISH, '0);
    // saturating add at the top
    add_token(KIND_PUSH, 32'sh7FFF_FFFF);
    add_token(KIND_PUSH, 32'sh0000_0001);
    add_token(KIND_ADD, '0);
    add_token(KIND_FINISH, '0);
    // saturating subtract at the bottom
    add_token(KIND_PUSH, 32'sh8000_0000);
    add_token(KIND_PUSH, 32'sh0000_0001);
    add_token(KIND_SUB, '1);
    add_token(KIND_FINISH, '1);
    // most negative squared saturates high
    add_token(KIND_PUSH, 32'sh8000_0000);
    add_token(KIND_PUSH, 32'sh8000_0000);
    add_token(KIND_MUL, '0);
    add_token(KIND_FINISH, '0);
    // tiny negative product rounds down to -1 lsb
    add_token(KIND_PUSH, 32'shFFFF_FFFF);
    add_token(KIND_PUSH, 32'sh0000_0001);
    add_token(KIND_MUL, '0);
    add_token(KIND_FINISH, '0);
    // operator short of an operand: invalid
    add_token(KIND_PUSH, 32'sh0005_0000);
    add_token(KIND_ADD, '0);
    add_token(KIND_FINISH, '0);
    // leftover operand: not empty
    add_token(KIND_PUSH, 32'sh0001_0000);
    add_token(KIND_PUSH, 32'sh0002_0000);
    add_token(KIND_FINISH, '0);
    // undefined kinds are swallowed
    add_token(3'd7, '1);
    add_token(3'd5, '0);

    while (live_tokens < 1425) begin
      shape = $urandom_range(0, 99);
      if (shape < 60) begin
        emit_expression($urandom_range(1, 8));
      end else if (shape < 68) begin
        emit_expression($urandom_range(9, DEPTH));
      end else if (shape < 78) begin
        // push past the stack bound
        repeat ($urandom_range(DEPTH + 1, DEPTH + 6)) add_token(KIND_PUSH, rand_number());
        repeat ($urandom_range(0, 3)) add_token(rand_op(), rand_number());
        add_token(KIND_FINISH, rand_number());
      end else if (shape < 86) begin
        // zero to two operands, then one to four operators
        repeat ($urandom_range(0, 2)) add_token(KIND_PUSH, rand_number());
        repeat ($urandom_range(1, 4)) add_token(rand_op(), rand_number());
        add_token(KIND_FINISH, rand_number());
      end else if (shape < 94) begin
        repeat ($urandom_range(1, 3)) add_token(KIND_PUSH, rand_number());
        emit_expression($urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 6)) add_token(KIND_W'($urandom_range(0, 7)), rand_number());
      end
    end

    while (token_q.size() != 0 || tok_accepted != tok_sent) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (outcome_q.size() != 0) report_failure("outcomes left over at end of run");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
